/* rtl/smce_pkg.sv */
`default_nettype none

package smce_pkg;

  // Row storage and class counting.
  localparam int MAX_CLASSES = 64;
  localparam int CLASS_BITS = $clog2(MAX_CLASSES);

  // Exp table geometry: entries span a difference of 0 to 16.0 in Q.8.
  localparam int EXP_TABLE_BITS = 8;
  localparam int EXP_SPAN_BITS = 12;
  localparam int EXP_ENTRIES = 1 << EXP_TABLE_BITS;
  localparam int EXP_SHIFT = EXP_SPAN_BITS - EXP_TABLE_BITS;
  localparam int EXP_STRIDE = 1 << EXP_SHIFT;
  localparam int EXP_FINE = 1 << EXP_SPAN_BITS;
  localparam logic [31:0] EXP_FINE_STEP = 32'd4278222805;
  localparam logic [23:0] EXP_ONE = 24'd65536;

  // Register indexes of the configuration port.
  localparam logic REG_CLASS_COUNT = 1'b0;
  localparam logic REG_BATCH_ROWS = 1'b1;

  typedef logic [16:0] exp_tbl_t [EXP_ENTRIES];

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  load;
    logic                  sum_clr;
    logic                  sum_acc;
    logic                  den_load;
    logic                  div_init;
    logic                  div_step;
    logic                  emit;
    logic [CLASS_BITS-1:0] addr;
  } smce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_close;
    logic last_class;
  } smce_stat_t;

  // exp(-x) in Q1.16 by repeated multiplication with exp(-1/256) in Q.32.
  function automatic exp_tbl_t build_exp_table();
    exp_tbl_t    tbl;
    logic [63:0] e;
    logic [63:0] r;
    e = 64'd1 << 32;
    for (int s = 0; s < EXP_FINE; s++) begin
      if ((s % EXP_STRIDE) == 0) begin
        r = (e + 64'd32768) >> 16;
        tbl[s / EXP_STRIDE] = r[16:0];
      end
      e = (e * {32'd0, EXP_FINE_STEP}) >> 32;
    end
    return tbl;
  endfunction

  localparam exp_tbl_t EXP_TABLE = build_exp_table();

endpackage

`default_nettype wire

/* rtl/smce_datapath.sv */
`default_nettype none

module smce_datapath
  import smce_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire smce_cmd_t                    cmd,
  output smce_stat_t                        stat,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [15:0]                  cfg_data,
  input  wire logic signed [15:0]           logit,
  input  wire logic [5:0]                   target_class,
  output logic                              result_valid,
  output logic signed [15:0]                gradient,
  output logic [5:0]                        class_index,
  output logic                              last_of_row,
  output logic                              target_error
);

  logic [6:0]             class_count;
  logic [15:0]            batch_rows;
  logic [6:0]             n_act;
  logic [15:0]            batch_eff;
  logic signed [15:0]     row_store [MAX_CLASSES];
  logic signed [15:0]     rdata;
  logic [CLASS_BITS-1:0]  fill;
  logic signed [15:0]     row_max;
  logic [5:0]             row_target;
  logic [23:0]            exp_sum;
  logic [23:0]            sum_floor;
  logic [16:0]            diff;
  logic [16:0]            e_val;
  logic [39:0]            prod;
  logic [39:0]            den;
  logic [39:0]            mag;
  logic                   is_tgt;
  logic [39:0]            rem;
  logic [54:0]            dsh;
  logic [15:0]            quo;
  logic                   neg;
  logic signed [15:0]     sat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= 7'd64;
      batch_rows <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLASS_COUNT: class_count <= cfg_data[6:0];
        REG_BATCH_ROWS:  batch_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // Active class count and divisor with the degenerate values mapped.
  always_comb begin
    if (class_count == 7'd0) begin
      n_act = 7'd1;
    end else if (class_count > 7'(MAX_CLASSES)) begin
      n_act = 7'(MAX_CLASSES);
    end else begin
      n_act = class_count;
    end
    batch_eff = (batch_rows == 16'd0) ? 16'd1 : batch_rows;
  end

  assign stat.row_close = (7'({1'b0, fill}) + 7'd1) >= n_act;
  assign stat.last_class = (7'({1'b0, cmd.addr}) + 7'd1) == n_act;

  // Row memory: one write on load, one registered read a cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_store[fill] <= logit;
    end
    rdata <= row_store[cmd.addr];
  end

  // Fill count, target and running maximum of the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      row_max <= -16'sd32768;
      row_target <= '0;
    end else if (cmd.load) begin
      if (fill == '0) begin
        row_target <= target_class;
        row_max <= logit;
      end else if (logit > row_max) begin
        row_max <= logit;
      end
      fill <= stat.row_close ? '0 : fill + 1'b1;
    end
  end

  // Exp lookup of the difference to the maximum; 16.0 and above gives zero.
  always_comb begin
    diff = 17'({row_max[15], row_max} - {rdata[15], rdata});
    if (diff[16:EXP_SPAN_BITS] != '0) begin
      e_val = '0;
    end else begin
      e_val = EXP_TABLE[diff[EXP_SPAN_BITS-1:EXP_SHIFT]];
    end
  end

  // Exp sum, floored at 1.0 when the divisor is formed.
  assign sum_floor = (exp_sum < EXP_ONE) ? EXP_ONE : exp_sum;
  assign prod = {16'd0, sum_floor} * {24'd0, batch_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_sum <= '0;
    end else if (cmd.sum_clr) begin
      exp_sum <= '0;
    end else if (cmd.sum_acc) begin
      exp_sum <= exp_sum + 24'(e_val);
    end else if (cmd.den_load) begin
      exp_sum <= sum_floor;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.den_load) begin
      den <= prod;
    end
  end

  // Numerator magnitude: the target class gives sum - e, others give e.
  always_comb begin
    is_tgt = (cmd.addr == row_target);
    if (is_tgt) begin
      mag = 40'(exp_sum - 24'(e_val)) << 15;
    end else begin
      mag = 40'(e_val) << 15;
    end
  end

  // Restoring division, one quotient bit a cycle, rounding by half the divisor.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= mag + (den >> 1);
      dsh <= 55'(den) << 15;
      quo <= '0;
      neg <= is_tgt && (exp_sum != 24'(e_val));
    end else if (cmd.div_step) begin
      if ({15'd0, rem} >= dsh) begin
        rem <= rem - dsh[39:0];
        quo <= {quo[14:0], 1'b1};
      end else begin
        quo <= {quo[14:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  // Sign and saturation of the quotient.
  always_comb begin
    if (neg) begin
      sat = (quo > 16'd32768) ? -16'sd32768 : 16'(-quo);
    end else begin
      sat = quo[15] ? 16'sd32767 : quo;
    end
  end

  // Result register, one beat per strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      gradient <= sat;
      class_index <= cmd.addr;
      last_of_row <= stat.last_class;
      target_error <= {1'b0, row_target} >= n_act;
    end
  end

`ifndef SYNTH
  // The last beat of a row is never followed directly by another beat.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_row |=> !result_valid)
    else $error("beat right after the last beat of a row");

  // The divisor is never zero once formed.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.den_load |=> den != '0)
    else $error("zero divisor");

  // The floored sum is at least 1.0 after the divisor is formed.
  a_sum_floor: assert property (@(posedge clk) disable iff (rst)
    cmd.den_load |=> exp_sum >= EXP_ONE)
    else $error("exp sum below 1.0");
`endif

endmodule

`default_nettype wire

/* rtl/smce_ctrl.sv */
`default_nettype none

module smce_ctrl
  import smce_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire smce_stat_t stat,
  output smce_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SUM_RD  = 3'd1;
  localparam logic [2:0] S_SUM_ACC = 3'd2;
  localparam logic [2:0] S_SCALE   = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_LD = 3'd5;
  localparam logic [2:0] S_DIV     = 3'd6;
  localparam logic [2:0] S_EMIT    = 3'd7;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [CLASS_BITS-1:0] cls;
  logic [CLASS_BITS-1:0] cls_next;
  logic [3:0]            bit_cnt;
  logic [3:0]            bit_cnt_next;

  assign busy = (state != S_IDLE);

  // Sequencer over load, sum, scale and divide-emit passes.
  always_comb begin
    state_next = state;
    cls_next = cls;
    bit_cnt_next = bit_cnt;
    cmd = '0;
    cmd.addr = cls;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.row_close) begin
            cmd.sum_clr = 1'b1;
            cls_next = '0;
            state_next = S_SUM_RD;
          end
        end
      end
      S_SUM_RD: begin
        state_next = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (stat.last_class) begin
          cls_next = '0;
          state_next = S_SCALE;
        end else begin
          cls_next = cls + 1'b1;
          state_next = S_SUM_RD;
        end
      end
      S_SCALE: begin
        cmd.den_load = 1'b1;
        state_next = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.div_init = 1'b1;
        bit_cnt_next = 4'd15;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        bit_cnt_next = bit_cnt - 1'b1;
        if (bit_cnt == 4'd0) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.last_class) begin
          cls_next = '0;
          state_next = S_IDLE;
        end else begin
          cls_next = cls + 1'b1;
          state_next = S_EMIT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cls <= '0;
      bit_cnt <= '0;
    end else begin
      state <= state_next;
      cls <= cls_next;
      bit_cnt <= bit_cnt_next;
    end
  end

`ifndef SYNTH
  // The divide runs exactly sixteen steps before the result beat.
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && bit_cnt == 4'd0 |=> state == S_EMIT)
    else $error("divide did not end in emit");

  // A row close always starts the sum pass at class zero.
  a_close: assert property (@(posedge clk) disable iff (rst)
    cmd.load && stat.row_close |=> state == S_SUM_RD && cls == '0)
    else $error("row close did not start the sum pass");

  // Emit of the last class returns to idle.
  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && stat.last_class |=> !busy)
    else $error("sequencer did not return to idle");
`endif

endmodule

`default_nettype wire

/* rtl/softmax_cross_entropy_gradient.sv */
`default_nettype none

// Softmax cross-entropy gradient. Pulse start with one logit while busy is low;
// the first logit of a row also carries target_class. Each logit is taken with its
// start pulse. After the configured class count of logits the block goes busy: a
// sum pass reads each class from memory, then looks up its exp and adds it; the
// divisor is then formed; and an emit pass reads each class, loads the divider,
// runs the one-bit-a-cycle divider over it and sends out its result. Results come
// in class order, each on the output ports for a single cycle with result_valid
// high; the receiver cannot stall them and must take every beat.
module softmax_cross_entropy_gradient
  import smce_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] logit,
  input  wire logic [5:0]         target_class,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    result_valid,
  output logic signed [15:0]      gradient,
  output logic [5:0]              class_index,
  output logic                    last_of_row,
  output logic                    target_error
);

  smce_cmd_t  cmd;
  smce_stat_t stat;

  smce_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  smce_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .logit        (logit),
    .target_class (target_class),
    .result_valid (result_valid),
    .gradient     (gradient),
    .class_index  (class_index),
    .last_of_row  (last_of_row),
    .target_error (target_error)
  );

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smce_pkg::*;

  // Block ports.
  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] logit;
  logic [5:0]         target_class;
  logic               cfg_we;
  logic               cfg_index;
  logic [15:0]        cfg_data;
  logic               result_valid;
  logic signed [15:0] gradient;
  logic [5:0]         class_index;
  logic               last_of_row;
  logic               target_error;

  softmax_cross_entropy_gradient uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .logit(logit), .target_class(target_class),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .gradient(gradient),
    .class_index(class_index), .last_of_row(last_of_row),
    .target_error(target_error)
  );

  // One gradient beat as the block should emit it.
  typedef struct {
    logic signed [15:0] grad;
    logic [5:0]         cls;
    logic               last;
    logic               terr;
  } grad_beat_t;

  grad_beat_t grad_q[$];

  // Shadow of the configuration and the row state.
  logic [6:0]         classes_reg;
  logic [15:0]        batch_reg;
  logic signed [15:0] shadow_row [64];
  logic [6:0]         shadow_fill;
  logic signed [15:0] shadow_max;
  logic [5:0]         shadow_target;
  logic [16:0]        exp_lut [256];

  int errors;
  int idle_cycles;
  int send_idle_pct;

  localparam int WATCHDOG_LIMIT = 6000;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // exp(-x) table in Q1.16, built by stepping exp(-1/256) in Q.32.
  function automatic void fill_exp_lut();
    longint unsigned acc;
    acc = 64'd1 << 32;
    for (int s = 0; s < 4096; s++) begin
      if (s % 16 == 0) exp_lut[s / 16] = 17'((acc + 64'd32768) >> 16);
      acc = (acc * 64'd4278222805) >> 32;
    end
  endfunction

  function automatic longint exp_of_diff(int d);
    int k;
    if (d < 0) d = 0;
    k = d >> 4;
    if (k >= 256) return 0;
    return longint'(exp_lut[k]);
  endfunction

  // Take one accepted logit; at row end queue the expected gradients.
  function automatic void gradient_predict(logic signed [15:0] lg, logic [5:0] tc);
    int     n;
    longint sum;
    longint den;
    longint num;
    longint mag;
    longint q;
    grad_beat_t b;
    n = (classes_reg == 0) ? 1 : (classes_reg > 64) ? 64 : int'(classes_reg);
    if (shadow_fill == 0) begin
      shadow_target = tc;
      shadow_max = -16'sd32768;
    end
    if (shadow_fill < 64) shadow_row[shadow_fill[5:0]] = lg;
    if (lg > shadow_max) shadow_max = lg;
    shadow_fill = shadow_fill + 7'd1;
    if (int'(shadow_fill) < n) return;
    sum = 0;
    for (int j = 0; j < n; j++) sum += exp_of_diff(int'(shadow_max) - int'(shadow_row[j]));
    if (sum < 65536) sum = 65536;
    sum = sum & 64'hFFFFFF;
    den = sum * ((batch_reg == 0) ? 1 : longint'(batch_reg));
    for (int j = 0; j < n; j++) begin
      num = exp_of_diff(int'(shadow_max) - int'(shadow_row[j])) * 32768;
      if (j == int'(shadow_target)) num -= sum * 32768;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      if (num < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      b.grad = 16'(q);
      b.cls = 6'(j);
      b.last = (j + 1 == n);
      b.terr = (int'(shadow_target) >= n);
      grad_q.push_back(b);
    end
    shadow_fill = 0;
    shadow_max = -16'sd32768;
  endfunction

  // Result checking and the watchdog on accepted beats.
  always @(posedge clk) begin
    grad_beat_t e;
    if (!rst) begin
      if (result_valid || (start && !busy)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (result_valid) begin
        if (grad_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected gradient beat class %0d", class_index);
        end else begin
          e = grad_q.pop_front();
          if (gradient !== e.grad || class_index !== e.cls || last_of_row !== e.last ||
              target_error !== e.terr) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp grad %0d cls %0d last %0b terr %0b, got %0d %0d %0b %0b",
                       e.grad, e.cls, e.last, e.terr,
                       gradient, class_index, last_of_row, target_error);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Send one logit beat, idling first at the current rate.
  task automatic send_logit(logic signed [15:0] lg, logic [5:0] tc);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    logit = lg;
    target_class = tc;
    @(posedge clk);
    while (busy) @(posedge clk);
    gradient_predict(lg, tc);
  endtask

  // Drain all expected beats, let the block settle, then write a register.
  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    start = 1'b0;
    while (grad_q.size() != 0 || busy) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_CLASS_COUNT) classes_reg = val[6:0];
    else batch_reg = val;
  endtask

  task automatic test_directed();
    write_reg(REG_CLASS_COUNT, 16'd4);
    // Extremes of the logit range.
    send_logit(16'sh7FFF, 6'd0);
    send_logit(-16'sh8000, 6'd63);
    send_logit(16'sd0, 6'd0);
    send_logit(-16'sd1, 6'd0);
    // Equal logits; target out of range.
    for (int i = 0; i < 4; i++) send_logit(16'sd256, 6'd5);
    // Zero and largest batch size.
    write_reg(REG_BATCH_ROWS, 16'd0);
    for (int i = 0; i < 4; i++) send_logit(16'(i * 300), 6'd3);
    write_reg(REG_BATCH_ROWS, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_logit(16'(-i * 90), 6'd1);
    // One class: target hit, then a non-target that saturates.
    write_reg(REG_BATCH_ROWS, 16'd1);
    write_reg(REG_CLASS_COUNT, 16'd1);
    send_logit(16'sd1000, 6'd0);
    send_logit(16'sd1000, 6'd2);
    // Zero class count behaves as one.
    write_reg(REG_CLASS_COUNT, 16'd0);
    send_logit(-16'sd5, 6'd0);
    // Class count lowered in the middle of a row.
    write_reg(REG_CLASS_COUNT, 16'd6);
    for (int i = 0; i < 4; i++) send_logit(16'(i * 70 - 100), 6'd1);
    write_reg(REG_CLASS_COUNT, 16'd2);
    send_logit(16'sd500, 6'd0);
  endtask

  // Whole rows with random sizes, targets and logits.
  task automatic test_random_rows(int pct, int count);
    int sent;
    int n;
    int pick;
    logic [15:0] base;
    logic [5:0]  tc;
    logic [15:0] lg;
    send_idle_pct = pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 5) write_reg(REG_CLASS_COUNT, 16'd127);
      else if (pick < 10) write_reg(REG_CLASS_COUNT, 16'd64);
      else if (pick < 40) write_reg(REG_CLASS_COUNT, 16'($urandom_range(8, 1)));
      pick = $urandom_range(99);
      if (pick < 10) write_reg(REG_BATCH_ROWS, 16'($urandom));
      else if (pick < 25) write_reg(REG_BATCH_ROWS, 16'($urandom_range(4, 1)));
      n = (classes_reg == 0) ? 1 : (classes_reg > 64) ? 64 : int'(classes_reg);
      tc = ($urandom_range(99) < 80) ? 6'($urandom_range(n - 1)) : 6'($urandom);
      base = 16'($urandom);
      for (int i = 0; i < n && sent < count; i++) begin
        lg = ($urandom_range(3) == 0) ? 16'($urandom)
                                      : base + 16'($urandom_range(2047)) - 16'd1024;
        send_logit(lg, tc);
        sent++;
      end
      // Now and then pause until every gradient of the row has come back.
      if ($urandom_range(9) == 0) begin
        @(negedge clk);
        start = 1'b0;
        while (grad_q.size() != 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    start = 1'b0;
    logit = '0;
    target_class = '0;
    cfg_we = 1'b0;
    cfg_index = REG_CLASS_COUNT;
    cfg_data = '0;
    classes_reg = 7'd64;
    batch_reg = 16'd1;
    shadow_fill = '0;
    shadow_max = -16'sd32768;
    shadow_target = '0;
    for (int i = 0; i < 64; i++) shadow_row[i] = '0;
    fill_exp_lut();
    rst = 1'b1;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_directed();
    // Finish any partial row so the random part starts clean.
    write_reg(REG_CLASS_COUNT, 16'd1);
    if (shadow_fill != 0) send_logit(16'sd0, 6'd0);
    test_random_rows(28, 145);
    test_random_rows(54, 145);
    test_random_rows(0, 144);

    @(negedge clk);
    start = 1'b0;
    while (grad_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/smce_pkg.sv
rtl/smce_datapath.sv
rtl/smce_ctrl.sv
rtl/softmax_cross_entropy_gradient.sv
test/tb.sv
